### rtl/acpp_pkg.sv
// Shared types, constants and helpers for the ASCII command packet parser.
package acpp_pkg;

	localparam int POS_W   = 5;
	localparam int VAL_W   = 14;
	localparam int TGT_W   = 4;
	localparam int ERR_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int RES_W   = 3 * VAL_W + TGT_W + 1 + ERR_W;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] HEADER_RST = 8'h41;

	localparam logic [VAL_W-1:0] VAL_MAX = 14'h3FFF;

	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_HEADER = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DIGIT  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_FIRE   = 2'd3;

	localparam logic [2:0] CMD_HEADER = 3'd0;
	localparam logic [2:0] CMD_SKIP   = 3'd1;
	localparam logic [2:0] CMD_DIGIT  = 3'd2;
	localparam logic [2:0] CMD_TARGET = 3'd3;
	localparam logic [2:0] CMD_FIRE   = 3'd4;

	localparam logic [1:0] FLD_YAW   = 2'd0;
	localparam logic [1:0] FLD_PITCH = 2'd1;
	localparam logic [1:0] FLD_DIST  = 2'd2;

	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       field;
		logic [TGT_W-1:0] digit;
		logic             bad;
		logic             fire;
	} cmd_t;

	typedef struct packed {
		logic [ERR_W-1:0] error_code;
		logic             fire_flag;
		logic [TGT_W-1:0] target_count;
		logic [VAL_W-1:0] distance_value;
		logic [VAL_W-1:0] pitch_value;
		logic [VAL_W-1:0] yaw_value;
	} result_t;

	// acc * 10 + d, saturating
	function automatic logic [VAL_W-1:0] acc_digit(input logic [VAL_W-1:0] acc,
			input logic [TGT_W-1:0] d);
		logic [VAL_W+3:0] v;
		v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{VAL_W{1'b0}}, d};
		if (v > {4'b0000, VAL_MAX}) begin
			return VAL_MAX;
		end
		return v[VAL_W-1:0];
	endfunction

endpackage

### rtl/ascii_command_packet_parser.sv
// ASCII command packet parser top level.
// One packet byte is taken per cycle on s_*; a packet is 4+3*DIGITS bytes
// (header, one ignored byte, yaw, pitch and distance fields of DIGITS decimal
// digits each, a target digit, and a fire byte '0'/'1'). The front end classifies
// each byte by its position and pushes a command into a two-entry queue; the
// back end accumulates the fields at one command per cycle and, on the fire
// command, loads the result register on m_* once any held result is taken.
// Sustained rate is one byte per cycle; input stalls only when the result
// register is still held and the queue has filled. On any error the values are
// zero and error_code gives the first error: 1 bad header, 2 non-digit, 3 bad
// fire byte. The expected header is written through cfg_* (reset 0x41).
module ascii_command_packet_parser import acpp_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,  // [7:0] byte_value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // yaw_value, pitch_value, distance_value,
	                                     // target_count, fire_flag, error_code, zero pad
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [BYTE_W-1:0]  cfg_data  // [7:0] header_byte
);

	logic [BYTE_W-1:0] header_q;
	logic              s_accept;
	cmd_t              front_cmd;
	cmd_t              back_cmd;
	logic              fifo_full;
	logic              fifo_empty;
	logic              pop;
	result_t           res;

	assign cfg_ready = 1'b1;
	assign s_tready  = !fifo_full;
	assign s_accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
		end else if (cfg_valid && cfg_ready) begin
			header_q <= cfg_data;
		end
	end

	acpp_front #(.DIGITS(DIGITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (s_accept),
		.byte_value  (s_tdata),
		.header_byte (header_q),
		.cmd         (front_cmd)
	);

	acpp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_accept),
		.push_cmd (front_cmd),
		.pop      (pop),
		.pop_cmd  (back_cmd),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	acpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!fifo_empty),
		.cmd       (back_cmd),
		.cmd_pop   (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, res};

	a_fifo_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_full && fifo_empty))
		else $error("queue both full and empty");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.error_code != ERR_NONE) |-> (m_tdata[RES_W-ERR_W-1:0] == '0))
		else $error("nonzero values with error");

	a_target_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.target_count <= TGT_W'(9)))
		else $error("target count out of range");

endmodule

### rtl/acpp_front.sv
// Front end: tracks byte position and classifies each byte into a command.
module acpp_front import acpp_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [BYTE_W-1:0] header_byte,
	output cmd_t              cmd
);

	localparam logic [POS_W-1:0] F1_START = POS_W'(2 + DIGITS);
	localparam logic [POS_W-1:0] F2_START = POS_W'(2 + 2 * DIGITS);
	localparam logic [POS_W-1:0] TGT_POS  = POS_W'(2 + 3 * DIGITS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(3 + 3 * DIGITS);

	logic [POS_W-1:0] pos_q;
	logic             is_digit;

	assign is_digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);

	always_comb begin
		cmd       = '0;
		cmd.digit = TGT_W'(byte_value - CHAR_ZERO);
		cmd.fire  = (byte_value == CHAR_ONE);
		if (pos_q == '0) begin
			cmd.kind = CMD_HEADER;
			cmd.bad  = (byte_value != header_byte);
		end else if (pos_q == POS_W'(1)) begin
			cmd.kind = CMD_SKIP;
		end else if (pos_q < TGT_POS) begin
			cmd.kind  = CMD_DIGIT;
			cmd.bad   = !is_digit;
			cmd.field = (pos_q >= F2_START) ? FLD_DIST :
			            (pos_q >= F1_START) ? FLD_PITCH : FLD_YAW;
		end else if (pos_q == TGT_POS) begin
			cmd.kind = CMD_TARGET;
			cmd.bad  = !is_digit;
		end else begin
			cmd.kind = CMD_FIRE;
			cmd.bad  = (byte_value != CHAR_ZERO) && (byte_value != CHAR_ONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
		end
	end

endmodule

### rtl/acpp_fifo.sv
// Two-entry command queue between front and back.
module acpp_fifo import acpp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/acpp_back.sv
// Back end: accumulates fields, tracks the first error, holds the result register.
module acpp_back import acpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	logic [VAL_W-1:0] yaw_q;
	logic [VAL_W-1:0] pitch_q;
	logic [VAL_W-1:0] dist_q;
	logic [TGT_W-1:0] tgt_q;
	logic [ERR_W-1:0] err_q;
	logic             res_valid_q;
	result_t          res_q;
	logic [ERR_W-1:0] fin_err;
	logic             ok;

	assign cmd_pop   = cmd_valid && ((cmd.kind != CMD_FIRE) || !res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign fin_err = (err_q != ERR_NONE) ? err_q : (cmd.bad ? ERR_FIRE : ERR_NONE);
	assign ok      = (fin_err == ERR_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= '0;
			pitch_q <= '0;
			dist_q  <= '0;
			tgt_q   <= '0;
			err_q   <= ERR_NONE;
		end else if (cmd_pop) begin
			priority if (cmd.kind == CMD_HEADER) begin
				yaw_q   <= '0;
				pitch_q <= '0;
				dist_q  <= '0;
				tgt_q   <= '0;
				err_q   <= cmd.bad ? ERR_HEADER : ERR_NONE;
			end else if (cmd.kind == CMD_DIGIT || cmd.kind == CMD_TARGET) begin
				if (cmd.bad) begin
					if (err_q == ERR_NONE) begin
						err_q <= ERR_DIGIT;
					end
				end else if (cmd.kind == CMD_TARGET) begin
					tgt_q <= cmd.digit;
				end else if (cmd.field == FLD_YAW) begin
					yaw_q <= acc_digit(yaw_q, cmd.digit);
				end else if (cmd.field == FLD_PITCH) begin
					pitch_q <= acc_digit(pitch_q, cmd.digit);
				end else begin
					dist_q <= acc_digit(dist_q, cmd.digit);
				end
			end else if (cmd.kind == CMD_FIRE) begin
				err_q <= fin_err;
			end else begin
				err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_pop && cmd.kind == CMD_FIRE) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == CMD_FIRE) begin
			res_q.error_code     <= fin_err;
			res_q.fire_flag      <= ok && cmd.fire;
			res_q.target_count   <= ok ? tgt_q : '0;
			res_q.distance_value <= ok ? dist_q : '0;
			res_q.pitch_value    <= ok ? pitch_q : '0;
			res_q.yaw_value      <= ok ? yaw_q : '0;
		end
	end

endmodule
